[hdl/svtds_pkg.sv]
package svtds_pkg;

    // Fixed field widths of the sprite interface.
    localparam int COORD_W    = 24;
    localparam int DIFF_W     = 25;
    localparam int ROT_W      = 16;
    localparam int PROF_W     = 8;
    localparam int PROD_W     = DIFF_W + ROT_W;
    localparam int ACC_W      = PROD_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_VIEWER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIEWER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_COS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_SIN  = 3'd3;

    // Saturation limits of a Q15.8 coordinate.
    localparam logic [COORD_W-1:0] Q8_MAX = 24'h7F_FFFF;
    localparam logic [COORD_W-1:0] Q8_MIN = 24'h80_0000;

    // One stored sprite after the view transform.
    typedef struct packed {
        logic signed [COORD_W-1:0] vx;
        logic signed [COORD_W-1:0] depth;
        logic [PROF_W-1:0]         prof;
    } entry_t;

    // Operation issued to the shared multiply-accumulate unit.
    typedef struct packed {
        logic valid;
        logic clr;
        logic sub;
    } mac_op_t;

endpackage

[hdl/sprite_view_transform_depth_sort.sv]
// Sprite view transform and depth sort.
// Input channel: one word per sprite (world_x, world_y, profile_id,
// last_sprite), taken when in_valid is high and in_stall is low. Each stored
// sprite is taken in ST_IDLE, then passes the transform steps in the shared
// multiply-accumulate unit that forms the rotated position. A sprite that
// arrives with the store full is dropped and sets the overflow flag; if it
// is marked last_sprite, the sort of the stored set still starts. After the
// word marked last_sprite, the n stored sprites are sorted farthest first in
// the sprite memory through its single read and single write port. Results
// then leave one per cycle on the output channel (out_valid, out_stall) while
// out_stall is low; the first is fetched in ST_EMIT_START and ST_EMIT_HEAD.
// Only sprites with positive depth are sent; if there is none, one word with
// none_visible set is sent. in_stall is high out of ST_IDLE: during a sprite's
// transform, and after the last sprite until the final result is loaded into
// the output register; a new set may start while that word waits. When the
// receiver stalls, the output word holds and the emit sequence waits.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once;
// each sprite uses the values in force when it is taken. Reset clears the
// stored count and the overflow flag and loads the register defaults.
module sprite_view_transform_depth_sort #(
    parameter int MAX_SPRITES = 32
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [svtds_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [svtds_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [svtds_pkg::COORD_W-1:0]    world_x,
    input  logic signed [svtds_pkg::COORD_W-1:0]    world_y,
    input  logic [svtds_pkg::PROF_W-1:0]            profile_id,
    input  logic                                    last_sprite,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [svtds_pkg::COORD_W-1:0]    view_x,
    output logic signed [svtds_pkg::COORD_W-1:0]    view_depth,
    output logic [svtds_pkg::PROF_W-1:0]            out_profile_id,
    output logic                                    last_result,
    output logic                                    none_visible,
    output logic                                    overflowed
);

    localparam int AW = $clog2(MAX_SPRITES);
    localparam int CW = $clog2(MAX_SPRITES + 1);

    // Steps of the transform sequence.
    localparam logic [2:0] XF_CDX  = 3'd0;
    localparam logic [2:0] XF_SDY  = 3'd1;
    localparam logic [2:0] XF_SDX  = 3'd2;
    localparam logic [2:0] XF_CDY  = 3'd3;
    localparam logic [2:0] XF_WAIT = 3'd4;
    localparam logic [2:0] XF_STORE = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_XFORM,
        ST_SORT_START,
        ST_SORT_FIRST,
        ST_SORT_CMP,
        ST_SORT_TAIL,
        ST_EMIT_START,
        ST_EMIT_HEAD,
        ST_EMIT_NEXT
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic signed [svtds_pkg::COORD_W-1:0] viewer_x_reg;
    logic signed [svtds_pkg::COORD_W-1:0] viewer_y_reg;
    logic signed [svtds_pkg::ROT_W-1:0]   rot_cos_reg;
    logic signed [svtds_pkg::ROT_W-1:0]   rot_sin_reg;

    // Sprite being transformed.
    logic signed [svtds_pkg::DIFF_W-1:0]  dx_reg;
    logic signed [svtds_pkg::DIFF_W-1:0]  dy_reg;
    logic signed [svtds_pkg::ROT_W-1:0]   cos_reg;
    logic signed [svtds_pkg::ROT_W-1:0]   sin_reg;
    logic [svtds_pkg::PROF_W-1:0]         prof_reg;
    logic                                 last_reg;
    logic [2:0]                           step_reg;
    logic signed [svtds_pkg::COORD_W-1:0] vx_reg;

    // Set bookkeeping and sort/emit pointers.
    logic [CW-1:0]      count_reg;
    logic               ovf_reg;
    logic [AW-1:0]      e_reg;
    logic [AW-1:0]      j_reg;
    logic [CW-1:0]      i_reg;
    svtds_pkg::entry_t  cur_reg;
    svtds_pkg::entry_t  hold_reg;

    // Output word.
    logic                                 out_valid_reg;
    logic signed [svtds_pkg::COORD_W-1:0] view_x_reg;
    logic signed [svtds_pkg::COORD_W-1:0] view_depth_reg;
    logic [svtds_pkg::PROF_W-1:0]         out_prof_reg;
    logic                                 last_result_reg;
    logic                                 none_visible_reg;
    logic                                 overflowed_reg;

    // Shared unit and memory connections.
    svtds_pkg::mac_op_t                   mac_op;
    logic signed [svtds_pkg::DIFF_W-1:0]  mac_a;
    logic signed [svtds_pkg::ROT_W-1:0]   mac_b;
    logic signed [svtds_pkg::COORD_W-1:0] mac_q8;
    logic                                 ram_we;
    logic [AW-1:0]                        ram_waddr;
    svtds_pkg::entry_t                    ram_wdata;
    logic                                 ram_re;
    logic [AW-1:0]                        ram_raddr;
    svtds_pkg::entry_t                    rdata;

    logic          accept;
    logic          out_free;
    logic          out_load;
    logic          next_bigger;
    logic          has_next;
    logic          visible0;
    logic [AW-1:0] j_inc;
    logic [AW-1:0] j_inc2;
    logic [CW-1:0] i_inc;

    svtds_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (mac_op),
        .a     (mac_a),
        .b     (mac_b),
        .q8    (mac_q8)
    );

    svtds_ram #(
        .DEPTH (MAX_SPRITES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            viewer_x_reg <= '0;
            viewer_y_reg <= '0;
            rot_cos_reg  <= 16'sd16384;
            rot_sin_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                svtds_pkg::REG_VIEWER_X: viewer_x_reg <= cfg_data;
                svtds_pkg::REG_VIEWER_Y: viewer_y_reg <= cfg_data;
                svtds_pkg::REG_ROT_COS:  rot_cos_reg  <= cfg_data[svtds_pkg::ROT_W-1:0];
                svtds_pkg::REG_ROT_SIN:  rot_sin_reg  <= cfg_data[svtds_pkg::ROT_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake and compare flags.
    assign in_stall    = (state_reg != ST_IDLE);
    assign accept      = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;
    assign out_load    = ((state_reg == ST_EMIT_HEAD) && !visible0 && out_free) ||
                         ((state_reg == ST_EMIT_NEXT) && out_free);
    assign next_bigger = $signed(cur_reg.depth) < $signed(rdata.depth);
    assign has_next    = (i_reg < count_reg) && ($signed(rdata.depth) > 0);
    assign visible0    = $signed(rdata.depth) > 0;
    assign j_inc       = j_reg + 1'b1;
    assign j_inc2      = j_inc + 1'b1;
    assign i_inc       = i_reg + 1'b1;

    // Operand selection for the shared multiply-accumulate unit.
    always_comb
    begin
        mac_op = '0;
        mac_a  = dy_reg;
        mac_b  = cos_reg;
        if (state_reg == ST_XFORM)
        begin
            unique case (step_reg)
                XF_CDX:
                begin
                    mac_op = '{valid: 1'b1, clr: 1'b1, sub: 1'b0};
                    mac_a  = dx_reg;
                    mac_b  = cos_reg;
                end
                XF_SDY:
                begin
                    mac_op = '{valid: 1'b1, clr: 1'b0, sub: 1'b1};
                    mac_a  = dy_reg;
                    mac_b  = sin_reg;
                end
                XF_SDX:
                begin
                    mac_op = '{valid: 1'b1, clr: 1'b1, sub: 1'b0};
                    mac_a  = dx_reg;
                    mac_b  = sin_reg;
                end
                XF_CDY:
                begin
                    mac_op = '{valid: 1'b1, clr: 1'b0, sub: 1'b0};
                    mac_a  = dy_reg;
                    mac_b  = cos_reg;
                end
                default: ;
            endcase
        end
    end

    // Memory port control for store, sort and emit.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = cur_reg;
        ram_re    = 1'b0;
        ram_raddr = '0;
        unique case (state_reg)
            ST_XFORM:
            begin
                if (step_reg == XF_STORE)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = count_reg[AW-1:0];
                    ram_wdata = '{vx: vx_reg, depth: mac_q8, prof: prof_reg};
                end
            end
            ST_SORT_START, ST_EMIT_START:
            begin
                ram_re = 1'b1;
            end
            ST_SORT_FIRST:
            begin
                ram_re    = 1'b1;
                ram_raddr = j_inc;
            end
            ST_SORT_CMP:
            begin
                // The larger of the pair is written back, the smaller moves on.
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                ram_wdata = next_bigger ? rdata : cur_reg;
                if (j_inc != e_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = j_inc2;
                end
            end
            ST_SORT_TAIL:
            begin
                ram_we    = 1'b1;
                ram_waddr = e_reg;
                ram_wdata = cur_reg;
                if (e_reg != AW'(1))
                begin
                    ram_re = 1'b1;
                end
            end
            ST_EMIT_HEAD:
            begin
                if (visible0 && (count_reg > CW'(1)))
                begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(1);
                end
            end
            ST_EMIT_NEXT:
            begin
                if (out_free && has_next && (i_inc < count_reg))
                begin
                    ram_re    = 1'b1;
                    ram_raddr = i_inc[AW-1:0];
                end
            end
            default: ;
        endcase
    end

    // Sequencer with its registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            dx_reg           <= '0;
            dy_reg           <= '0;
            cos_reg          <= '0;
            sin_reg          <= '0;
            prof_reg         <= '0;
            last_reg         <= 1'b0;
            step_reg         <= '0;
            vx_reg           <= '0;
            count_reg        <= '0;
            ovf_reg          <= 1'b0;
            e_reg            <= '0;
            j_reg            <= '0;
            i_reg            <= '0;
            cur_reg          <= '0;
            hold_reg         <= '0;
            out_valid_reg    <= 1'b0;
            view_x_reg       <= '0;
            view_depth_reg   <= '0;
            out_prof_reg     <= '0;
            last_result_reg  <= 1'b0;
            none_visible_reg <= 1'b0;
            overflowed_reg   <= 1'b0;
        end
        else
        begin
            // The output word is valid from its load until it is taken.
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        dx_reg   <= svtds_pkg::DIFF_W'(world_x) -
                                    svtds_pkg::DIFF_W'(viewer_x_reg);
                        dy_reg   <= svtds_pkg::DIFF_W'(world_y) -
                                    svtds_pkg::DIFF_W'(viewer_y_reg);
                        cos_reg  <= rot_cos_reg;
                        sin_reg  <= rot_sin_reg;
                        prof_reg <= profile_id;
                        last_reg <= last_sprite;
                        if (count_reg < CW'(MAX_SPRITES))
                        begin
                            step_reg  <= XF_CDX;
                            state_reg <= ST_XFORM;
                        end
                        else
                        begin
                            // Store full: drop the sprite.
                            ovf_reg <= 1'b1;
                            if (last_sprite)
                            begin
                                e_reg     <= AW'(MAX_SPRITES - 1);
                                state_reg <= ST_SORT_START;
                            end
                        end
                    end
                end
                ST_XFORM:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == XF_CDY)
                    begin
                        vx_reg <= mac_q8;
                    end
                    if (step_reg == XF_STORE)
                    begin
                        count_reg <= count_reg + 1'b1;
                        if (!last_reg)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else if (count_reg == '0)
                        begin
                            state_reg <= ST_EMIT_START;
                        end
                        else
                        begin
                            e_reg     <= count_reg[AW-1:0];
                            state_reg <= ST_SORT_START;
                        end
                    end
                end
                ST_SORT_START:
                begin
                    j_reg     <= '0;
                    state_reg <= ST_SORT_FIRST;
                end
                ST_SORT_FIRST:
                begin
                    cur_reg   <= rdata;
                    state_reg <= ST_SORT_CMP;
                end
                ST_SORT_CMP:
                begin
                    if (!next_bigger)
                    begin
                        cur_reg <= rdata;
                    end
                    if (j_inc == e_reg)
                    begin
                        state_reg <= ST_SORT_TAIL;
                    end
                    else
                    begin
                        j_reg <= j_inc;
                    end
                end
                ST_SORT_TAIL:
                begin
                    if (e_reg == AW'(1))
                    begin
                        state_reg <= ST_EMIT_START;
                    end
                    else
                    begin
                        e_reg     <= e_reg - 1'b1;
                        j_reg     <= '0;
                        state_reg <= ST_SORT_FIRST;
                    end
                end
                ST_EMIT_START:
                begin
                    state_reg <= ST_EMIT_HEAD;
                end
                ST_EMIT_HEAD:
                begin
                    if (visible0)
                    begin
                        hold_reg  <= rdata;
                        i_reg     <= CW'(1);
                        state_reg <= ST_EMIT_NEXT;
                    end
                    else if (out_free)
                    begin
                        // Nothing in front of the viewer.
                        view_x_reg       <= '0;
                        view_depth_reg   <= '0;
                        out_prof_reg     <= '0;
                        last_result_reg  <= 1'b1;
                        none_visible_reg <= 1'b1;
                        overflowed_reg   <= ovf_reg;
                        count_reg        <= '0;
                        ovf_reg          <= 1'b0;
                        state_reg        <= ST_IDLE;
                    end
                end
                ST_EMIT_NEXT:
                begin
                    if (out_free)
                    begin
                        view_x_reg       <= hold_reg.vx;
                        view_depth_reg   <= hold_reg.depth;
                        out_prof_reg     <= hold_reg.prof;
                        last_result_reg  <= !has_next;
                        none_visible_reg <= 1'b0;
                        overflowed_reg   <= ovf_reg;
                        if (has_next)
                        begin
                            hold_reg <= rdata;
                            i_reg    <= i_inc;
                        end
                        else
                        begin
                            count_reg <= '0;
                            ovf_reg   <= 1'b0;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign view_x         = view_x_reg;
    assign view_depth     = view_depth_reg;
    assign out_profile_id = out_prof_reg;
    assign last_result    = last_result_reg;
    assign none_visible   = none_visible_reg;
    assign overflowed     = overflowed_reg;

`ifndef NO_ASSERTIONS
    // The stored count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_SPRITES))
        else $error("sprite count beyond capacity");

    // An empty-set word is the only word of its set and carries no position.
    a_none_form: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && none_visible) |->
        (last_result && (view_x == '0) && (view_depth == '0) && (out_profile_id == '0)))
        else $error("malformed none_visible word");

    // Every sprite sent lies in front of the viewer.
    a_visible_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !none_visible) |-> ($signed(view_depth) > 0))
        else $error("sprite sent with non-positive depth");

    // The emit sequence never loads a new word over one that is still stalled.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(view_depth) && $stable(out_profile_id))
        else $error("output word changed while stalled");
`endif

endmodule

[hdl/svtds_mac.sv]
module svtds_mac (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  svtds_pkg::mac_op_t                   op,
    input  logic signed [svtds_pkg::DIFF_W-1:0]  a,
    input  logic signed [svtds_pkg::ROT_W-1:0]   b,
    output logic signed [svtds_pkg::COORD_W-1:0] q8
);

    svtds_pkg::mac_op_t                  op_reg;
    logic signed [svtds_pkg::PROD_W-1:0] prod_reg;
    logic signed [svtds_pkg::PROD_W-1:0] prod_next;
    logic signed [svtds_pkg::ACC_W-1:0]  acc_reg;
    logic signed [svtds_pkg::ACC_W-1:0]  acc_next;
    logic signed [svtds_pkg::ACC_W-1:0]  prod_ext;
    logic signed [svtds_pkg::ACC_W-1:0]  rnd;
    logic signed [svtds_pkg::ACC_W-15:0] shifted;

    // Product stage.
    assign prod_next = a * b;

    // Accumulate stage: add or subtract the registered product, from zero on clr.
    assign prod_ext = svtds_pkg::ACC_W'(prod_reg);
    always_comb
    begin
        acc_next = op_reg.clr ? '0 : acc_reg;
        if (op_reg.sub)
        begin
            acc_next = acc_next - prod_ext;
        end
        else
        begin
            acc_next = acc_next + prod_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg   <= '0;
            prod_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            op_reg   <= op;
            prod_reg <= prod_next;
            if (op_reg.valid)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    // Round the Q.22 sum half up to Q.8, then saturate to 24 bits.
    assign rnd     = acc_reg + svtds_pkg::ACC_W'(8192);
    assign shifted = rnd[svtds_pkg::ACC_W-1:14];

    always_comb
    begin
        if ((&shifted[27:23]) || !(|shifted[27:23]))
        begin
            q8 = shifted[svtds_pkg::COORD_W-1:0];
        end
        else if (shifted[27])
        begin
            q8 = svtds_pkg::Q8_MIN;
        end
        else
        begin
            q8 = svtds_pkg::Q8_MAX;
        end
    end

endmodule

[hdl/svtds_ram.sv]
module svtds_ram #(
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  svtds_pkg::entry_t        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output svtds_pkg::entry_t        rdata
);

    svtds_pkg::entry_t mem [DEPTH];
    svtds_pkg::entry_t rdata_reg;

    // One write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sim/sprite_view_transform_depth_sort_tb.sv]
`timescale 1ns / 100ps

module sprite_view_transform_depth_sort_tb;

    localparam int MAX_SPRITES   = 32;
    localparam int NUM_REGS      = 4;
    localparam int HOLD_AT       = 100;
    localparam int HOLD_CYCLES   = 2000;
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASE_ITEMS   = 36;

    // One sprite word as offered on the input channel.
    typedef struct {
        logic signed [svtds_pkg::COORD_W-1:0] wx;
        logic signed [svtds_pkg::COORD_W-1:0] wy;
        logic [svtds_pkg::PROF_W-1:0]         prof;
        logic                                 last;
    } sprite_t;

    // One result word as seen on the output channel.
    typedef struct {
        logic signed [svtds_pkg::COORD_W-1:0] vx;
        logic signed [svtds_pkg::COORD_W-1:0] depth;
        logic [svtds_pkg::PROF_W-1:0]         prof;
        logic                                 last;
        logic                                 none;
        logic                                 ovf;
    } view_word_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 cfg_we = 1'b0;
    logic [svtds_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [svtds_pkg::CFG_DATA_W-1:0]     cfg_data = '0;
    logic                                 in_valid = 1'b0;
    logic                                 in_stall;
    logic signed [svtds_pkg::COORD_W-1:0] world_x = '0;
    logic signed [svtds_pkg::COORD_W-1:0] world_y = '0;
    logic [svtds_pkg::PROF_W-1:0]         profile_id = '0;
    logic                                 last_sprite = 1'b0;
    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    logic signed [svtds_pkg::COORD_W-1:0] view_x;
    logic signed [svtds_pkg::COORD_W-1:0] view_depth;
    logic [svtds_pkg::PROF_W-1:0]         out_profile_id;
    logic                                 last_result;
    logic                                 none_visible;
    logic                                 overflowed;

    // Viewer state and set store as the block should hold them.
    logic signed [svtds_pkg::COORD_W-1:0] eye_x = '0;
    logic signed [svtds_pkg::COORD_W-1:0] eye_y = '0;
    logic signed [svtds_pkg::ROT_W-1:0]   rot_c = 16'sd16384;
    logic signed [svtds_pkg::ROT_W-1:0]   rot_s = '0;
    svtds_pkg::entry_t                    set_mem [MAX_SPRITES];
    int                                   set_count = 0;
    logic                                 set_dropped = 1'b0;

    sprite_t    pending_sprites [$];
    view_word_t expected_views [$];
    sprite_t    offered;
    sprite_t    prev_sprite = '{default: '0};
    int         sprites_taken = 0;
    int         words_seen = 0;
    int         mismatches = 0;
    int         tx_gap = 0;
    int         rx_gap = 0;
    int         hold_left = 0;
    logic       hold_done = 1'b0;
    logic       quiet_run = 1'b0;

    sprite_view_transform_depth_sort #(
        .MAX_SPRITES(MAX_SPRITES)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .world_x       (world_x),
        .world_y       (world_y),
        .profile_id    (profile_id),
        .last_sprite   (last_sprite),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .view_x        (view_x),
        .view_depth    (view_depth),
        .out_profile_id(out_profile_id),
        .last_result   (last_result),
        .none_visible  (none_visible),
        .overflowed    (overflowed)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Round a Q.22 product sum half up to Q.8 and clamp it to 24 bits.
    function automatic logic signed [svtds_pkg::COORD_W-1:0] q22_to_q8(longint acc);
        longint r;
        r = (acc + 64'sd8192) >>> 14;
        if (r > 64'sd8388607)
            r = 64'sd8388607;
        else if (r < -64'sd8388608)
            r = -64'sd8388608;
        return r[svtds_pkg::COORD_W-1:0];
    endfunction

    // Transform one sprite into view space and, on the last of a set, sort the
    // set farthest first and queue the words it should produce.
    function automatic void transform_and_sort(sprite_t s);
        longint            dx;
        longint            dy;
        longint            c;
        longint            sn;
        svtds_pkg::entry_t tmp;
        view_word_t        w;
        int                n;
        int                shown;
        dx = longint'(s.wx) - longint'(eye_x);
        dy = longint'(s.wy) - longint'(eye_y);
        c  = longint'(rot_c);
        sn = longint'(rot_s);
        if (set_count < MAX_SPRITES)
        begin
            set_mem[set_count].vx    = q22_to_q8(c * dx - sn * dy);
            set_mem[set_count].depth = q22_to_q8(sn * dx + c * dy);
            set_mem[set_count].prof  = s.prof;
            set_count++;
        end
        else
        begin
            set_dropped = 1'b1;
        end
        if (!s.last)
            return;

        // Stable bubble order, deepest first.
        n = set_count;
        for (int i = 0; i < n; i++)
        begin
            for (int j = 0; j + 1 + i < n; j++)
            begin
                if ($signed(set_mem[j].depth) < $signed(set_mem[j + 1].depth))
                begin
                    tmp            = set_mem[j];
                    set_mem[j]     = set_mem[j + 1];
                    set_mem[j + 1] = tmp;
                end
            end
        end

        // Visible sprites form a prefix of the sorted set.
        shown = 0;
        for (int i = 0; i < n; i++)
        begin
            if ($signed(set_mem[i].depth) <= 0)
                break;
            w.vx    = set_mem[i].vx;
            w.depth = set_mem[i].depth;
            w.prof  = set_mem[i].prof;
            w.last  = (i + 1 == n) || ($signed(set_mem[i + 1].depth) <= 0);
            w.none  = 1'b0;
            w.ovf   = set_dropped;
            expected_views.push_back(w);
            shown++;
        end
        if (shown == 0)
        begin
            w.vx    = '0;
            w.depth = '0;
            w.prof  = '0;
            w.last  = 1'b1;
            w.none  = 1'b1;
            w.ovf   = set_dropped;
            expected_views.push_back(w);
        end
        set_count   = 0;
        set_dropped = 1'b0;
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("MISMATCH word %0d %s: got %h expected %h", words_seen, what, got, want);
    endtask

    // Sender: offers pending sprites, with random bursts of idle cycles.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                transform_and_sort(offered);
                sprites_taken <= sprites_taken + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (tx_gap > 0)
                begin
                    in_valid <= 1'b0;
                    tx_gap   <= tx_gap - 1;
                end
                else if (!quiet_run && $urandom_range(0, 9) == 0)
                begin
                    in_valid <= 1'b0;
                    tx_gap   <= $urandom_range(0, 13);
                end
                else if (pending_sprites.size() != 0)
                begin
                    offered     = pending_sprites.pop_front();
                    world_x     <= offered.wx;
                    world_y     <= offered.wy;
                    profile_id  <= offered.prof;
                    last_sprite <= offered.last;
                    in_valid    <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off once the run is well under way, so that the
    // emit sequence waits and the block holds its input stalled.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && sprites_taken >= HOLD_AT)
            begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
            end
        end
    end

    // Receiver: checks each accepted word and stalls in random bursts.
    always @(posedge clk)
    begin
        view_word_t w;
        logic       burst;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                words_seen++;
                if (expected_views.size() == 0)
                begin
                    flag_mismatch("word with nothing expected", {8'h0, view_depth}, '0);
                end
                else
                begin
                    w = expected_views.pop_front();
                    if (view_x !== w.vx)
                        flag_mismatch("view_x", {8'h0, view_x}, {8'h0, w.vx});
                    if (view_depth !== w.depth)
                        flag_mismatch("view_depth", {8'h0, view_depth}, {8'h0, w.depth});
                    if (out_profile_id !== w.prof)
                        flag_mismatch("out_profile_id", {24'h0, out_profile_id}, {24'h0, w.prof});
                    if (last_result !== w.last)
                        flag_mismatch("last_result", {31'h0, last_result}, {31'h0, w.last});
                    if (none_visible !== w.none)
                        flag_mismatch("none_visible", {31'h0, none_visible}, {31'h0, w.none});
                    if (overflowed !== w.ovf)
                        flag_mismatch("overflowed", {31'h0, overflowed}, {31'h0, w.ovf});
                end
            end
            burst = 1'b0;
            if (rx_gap > 0)
            begin
                burst = 1'b1;
                rx_gap <= rx_gap - 1;
            end
            else if (!quiet_run && $urandom_range(0, 7) == 0)
            begin
                burst = 1'b1;
                rx_gap <= $urandom_range(0, 13);
            end
            out_stall <= burst || (hold_left > 0);
        end
    end

    function automatic void queue_sprite(int x, int y, int p, logic last);
        sprite_t s;
        s.wx   = 24'(x);
        s.wy   = 24'(y);
        s.prof = 8'(p);
        s.last = last;
        pending_sprites.push_back(s);
    endfunction

    // Random sprite: mostly close to the viewer, some anywhere, some on the
    // same spot as the one before so that equal depths come up.
    function automatic sprite_t make_sprite(logic last);
        sprite_t s;
        int      mode;
        int      ox;
        int      oy;
        mode = $urandom_range(0, 99);
        ox   = $urandom_range(0, 8191) - 4096;
        oy   = $urandom_range(0, 8191) - 4096;
        if (mode < 25)
        begin
            s.wx = 24'($urandom);
            s.wy = 24'($urandom);
        end
        else if (mode < 85)
        begin
            s.wx = eye_x + ox[svtds_pkg::COORD_W-1:0];
            s.wy = eye_y + oy[svtds_pkg::COORD_W-1:0];
        end
        else
        begin
            s.wx = prev_sprite.wx;
            s.wy = prev_sprite.wy;
        end
        s.prof = 8'($urandom);
        s.last = last;
        prev_sprite = s;
        return s;
    endfunction

    function automatic int queue_set(int size);
        for (int i = 0; i < size; i++)
            pending_sprites.push_back(make_sprite(i == size - 1));
        return size;
    endfunction

    function automatic int pick_set_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 6);
        else if (r < 90)
            return $urandom_range(7, 16);
        else if (r < 97)
            return $urandom_range(17, MAX_SPRITES);
        return $urandom_range(MAX_SPRITES + 1, MAX_SPRITES + 4);
    endfunction

    // Waits until every sprite is taken and every word has come, then lets
    // the block settle before anything is reconfigured.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_sprites.size() != 0 || in_valid || expected_views.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [svtds_pkg::CFG_IDX_W-1:0] idx,
                             logic [svtds_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            svtds_pkg::REG_VIEWER_X: eye_x = value;
            svtds_pkg::REG_VIEWER_Y: eye_y = value;
            svtds_pkg::REG_ROT_COS:  rot_c = value[svtds_pkg::ROT_W-1:0];
            svtds_pkg::REG_ROT_SIN:  rot_s = value[svtds_pkg::ROT_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [svtds_pkg::CFG_DATA_W-1:0] rot_word(int term);
        return {8'($urandom), 16'(term)};
    endfunction

    // Stimulus: directed sets at the reset settings, then phases of random
    // sets, each under its own viewer position and rotation.
    initial
    begin
        int made;
        int unused_idx;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Identity rotation: equal depths, field extremes, a sprite behind.
        queue_sprite(32'h7FFFFF, 256, 8'h01, 1'b0);
        queue_sprite(-8388608, 256, 8'h02, 1'b0);
        queue_sprite(5, -8388608, 8'hFF, 1'b0);
        queue_sprite(0, 8388607, 8'h80, 1'b0);
        queue_sprite(1, 256, 8'h03, 1'b1);
        // Nothing in front of the viewer.
        queue_sprite(0, 0, 8'h10, 1'b0);
        queue_sprite(3, -1, 8'h11, 1'b1);
        // One-sprite sets: just in front, and exactly at depth zero.
        queue_sprite(-1, 1, 8'h55, 1'b1);
        queue_sprite(-1, 0, 8'hAA, 1'b1);

        for (int phase = 1; phase <= 7; phase++)
        begin
            wait_idle();
            case (phase)
                1:
                begin
                    write_reg(svtds_pkg::REG_VIEWER_X, 24'h7F_FFFF);
                    write_reg(svtds_pkg::REG_VIEWER_Y, 24'h80_0000);
                    write_reg(svtds_pkg::REG_ROT_COS, rot_word(-16384));
                    write_reg(svtds_pkg::REG_ROT_SIN, rot_word(16384));
                end
                2:
                begin
                    write_reg(svtds_pkg::REG_VIEWER_X, 24'h80_0000);
                    write_reg(svtds_pkg::REG_VIEWER_Y, 24'h7F_FFFF);
                    write_reg(svtds_pkg::REG_ROT_COS, rot_word(16384));
                    write_reg(svtds_pkg::REG_ROT_SIN, rot_word(-16384));
                end
                3:
                begin
                    // Rotation terms outside the unit range, so that results can saturate.
                    write_reg(svtds_pkg::REG_VIEWER_X, 24'($urandom));
                    write_reg(svtds_pkg::REG_VIEWER_Y, 24'($urandom));
                    write_reg(svtds_pkg::REG_ROT_COS, rot_word(-32768));
                    write_reg(svtds_pkg::REG_ROT_SIN, rot_word(32767));
                end
                default:
                begin
                    write_reg(svtds_pkg::REG_VIEWER_X, 24'($urandom));
                    write_reg(svtds_pkg::REG_VIEWER_Y, 24'($urandom));
                    write_reg(svtds_pkg::REG_ROT_COS,
                              rot_word($urandom_range(0, 32768) - 16384));
                    write_reg(svtds_pkg::REG_ROT_SIN,
                              rot_word($urandom_range(0, 32768) - 16384));
                end
            endcase
            // An index past the register list must change nothing.
            unused_idx = NUM_REGS + $urandom_range(0, 3);
            write_reg(unused_idx[svtds_pkg::CFG_IDX_W-1:0], 24'($urandom));
            quiet_run = (phase == 7);

            made = 0;
            if (phase == 1)
            begin
                // World extremes against the far corner viewer.
                queue_sprite(32'h7FFFFF, 32'h7FFFFF, 8'h21, 1'b0);
                queue_sprite(-8388608, -8388608, 8'h22, 1'b0);
                queue_sprite(-8388608, 32'h7FFFFF, 8'h23, 1'b0);
                queue_sprite(32'h7FFFFF, -8388608, 8'h24, 1'b0);
                queue_sprite(0, 0, 8'h25, 1'b1);
            end
            else if (phase == 3)
            begin
                // Store full when the last sprite arrives: it is dropped.
                made += queue_set(MAX_SPRITES + 1);
            end
            else if (phase == 5)
            begin
                made += queue_set(MAX_SPRITES + 4);
            end
            while (made < PHASE_ITEMS)
                made += queue_set(pick_set_size());
        end

        wait_idle();
        if (mismatches == 0 && expected_views.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
